FILE: rtl/fbpa_pkg.sv
// Shared constants, codes and types of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 8;
  localparam int SIZE_W     = 16;
  localparam int OFS_W      = 24;
  localparam int POOL_W     = IDX_W + 1;

  // Used marks are stored eight to a row
  localparam int WORD_W = 8;
  localparam int BIT_W  = 3;
  localparam int ROWS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Reset values of the registers and the free count
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 8'd255;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
  localparam logic [CNT_W-1:0]  FREE_COUNT_RST  =
      CNT_W'((MAX_BLOCKS < 255) ? MAX_BLOCKS : 255);

  // Request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  // Register indexes
  localparam logic [7:0] REG_BLOCK_COUNT = 8'd0;
  localparam logic [7:0] REG_BLOCK_SIZE  = 8'd1;

  // Request from the sequencer to the used-mark store
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clear;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] wr_word;
  } bm_req_t;

endpackage

`default_nettype wire

FILE: rtl/fbpa_bitmap.sv
// Used-mark store: row memory with per-row valid bits, so that a clear resets every row at once.
`default_nettype none

module fbpa_bitmap (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbpa_pkg::bm_req_t             req_i,
  output logic [fbpa_pkg::WORD_W-1:0]        rd_word_o
);

  logic [fbpa_pkg::WORD_W-1:0] mem_q [fbpa_pkg::ROWS];
  logic [fbpa_pkg::ROWS-1:0]   row_valid_q;
  logic [fbpa_pkg::WORD_W-1:0] rd_data_q;
  logic                        rd_valid_q;

  // Row memory, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.row] <= req_i.wr_word;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.row];
    end
  end

  // Row valid bits; a row never written since the last clear reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        row_valid_q <= '0;
      end else if (req_i.wr_en) begin
        row_valid_q[req_i.row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.row];
      end
    end
  end

  assign rd_word_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request sequencer and registers.
//
// Usage:
//   A request (func_i, block_index_i) is taken at a clock edge where start is
//   high and busy is low. Allocate grants the lowest-numbered free block;
//   free releases the named block. Each request gives one result on
//   status_o, granted_index_o, byte_offset_o and free_remaining_o, shown for
//   exactly one cycle with done_o high. The receiver cannot stall.
//   Steps: a free reads its mark row, checks and writes it, multiplies
//   the offset and shows the result. An allocate scans the 8-block rows
//   one by one (1 to 32 rows), since the mark store gives one registered
//   row per read and each row is read and tested in turn. A failed request
//   (empty pool, bad free) skips the multiply.
//   One request is in flight at a time; busy falls
//   in the done cycle, so the next request may be taken then.
//   Registers are written over the cfg_* channel while busy is low; writing
//   block_count frees every block at once. Reset frees every block, with
//   255 blocks of 64 bytes.
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func_i,
  input  wire logic [fbpa_pkg::IDX_W-1:0]    block_index_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [7:0]                    cfg_index_i,
  input  wire logic [fbpa_pkg::SIZE_W-1:0]   cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [fbpa_pkg::IDX_W-1:0]         granted_index_o,
  output logic [fbpa_pkg::OFS_W-1:0]         byte_offset_o,
  output logic [fbpa_pkg::CNT_W-1:0]         free_remaining_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic                          func_q;
  logic [fbpa_pkg::IDX_W-1:0]    idx_q;
  logic [fbpa_pkg::ROW_W-1:0]    row_q, row_d;
  logic [fbpa_pkg::IDX_W-1:0]    grant_q;
  logic [fbpa_pkg::CNT_W-1:0]    block_count_q;
  logic [fbpa_pkg::SIZE_W-1:0]   block_size_q;
  logic [fbpa_pkg::CNT_W-1:0]    free_count_q;
  logic                          done_q;
  logic [1:0]                    status_q;
  logic [fbpa_pkg::IDX_W-1:0]    res_idx_q;
  logic [fbpa_pkg::OFS_W-1:0]    res_ofs_q;
  logic [fbpa_pkg::CNT_W-1:0]    res_free_q;

  logic                          accept;
  logic                          cfg_we;
  logic                          cfg_count_we;
  logic [fbpa_pkg::POOL_W-1:0]   pool_n;
  logic [fbpa_pkg::POOL_W-1:0]   cfg_pool_n;
  logic [fbpa_pkg::POOL_W-1:0]   next_base;
  logic [fbpa_pkg::WORD_W-1:0]   word;
  logic                          alloc_hit;
  logic [fbpa_pkg::BIT_W-1:0]    alloc_bit;
  logic [fbpa_pkg::BIT_W-1:0]    free_bit;
  logic                          free_ok;
  logic                          eval_ok;
  logic                          eval_fail;
  logic [fbpa_pkg::IDX_W-1:0]    eval_idx;
  logic [fbpa_pkg::WORD_W-1:0]   eval_word;
  logic [1:0]                    fail_status;
  fbpa_pkg::bm_req_t             bm_req;

  // Handshakes
  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = !busy;
  assign cfg_we       = cfg_valid_i && cfg_ready_o;
  assign cfg_count_we = cfg_we && (cfg_index_i == fbpa_pkg::REG_BLOCK_COUNT);

  // Effective pool size, now and after a block_count write
  assign pool_n = ({1'b0, block_count_q} > fbpa_pkg::POOL_W'(fbpa_pkg::MAX_BLOCKS)) ?
                  fbpa_pkg::POOL_W'(fbpa_pkg::MAX_BLOCKS) : {1'b0, block_count_q};
  assign cfg_pool_n = ({1'b0, cfg_data_i[fbpa_pkg::CNT_W-1:0]} >
                       fbpa_pkg::POOL_W'(fbpa_pkg::MAX_BLOCKS)) ?
                      fbpa_pkg::POOL_W'(fbpa_pkg::MAX_BLOCKS) :
                      {1'b0, cfg_data_i[fbpa_pkg::CNT_W-1:0]};

  // First block of the row after the current one
  assign next_base = fbpa_pkg::POOL_W'({({1'b0, row_q} + 1'b1), fbpa_pkg::BIT_W'(0)});

  // Lowest free in-range block of the current row
  always_comb begin
    alloc_hit = 1'b0;
    alloc_bit = '0;
    for (int b = fbpa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!word[b] &&
          (fbpa_pkg::POOL_W'({row_q, fbpa_pkg::BIT_W'(b)}) < pool_n)) begin
        alloc_hit = 1'b1;
        alloc_bit = fbpa_pkg::BIT_W'(b);
      end
    end
  end

  // Free check: in range and currently used
  assign free_bit = idx_q[fbpa_pkg::BIT_W-1:0];
  assign free_ok  = (fbpa_pkg::POOL_W'(idx_q) < pool_n) && word[free_bit];

  // Outcome of the evaluate step
  always_comb begin
    eval_ok     = 1'b0;
    eval_fail   = 1'b0;
    eval_idx    = idx_q;
    eval_word   = word;
    fail_status = fbpa_pkg::STAT_BAD;
    if (func_q == fbpa_pkg::FUNC_ALLOC) begin
      fail_status = fbpa_pkg::STAT_EMPTY;
      eval_idx    = fbpa_pkg::IDX_W'({row_q, alloc_bit});
      eval_word   = word | (fbpa_pkg::WORD_W'(1) << alloc_bit);
      if (alloc_hit) begin
        eval_ok = 1'b1;
      end else if (next_base >= pool_n) begin
        eval_fail = 1'b1;
      end
    end else begin
      eval_word = word & ~(fbpa_pkg::WORD_W'(1) << free_bit);
      if (free_ok) begin
        eval_ok = 1'b1;
      end else begin
        eval_fail = 1'b1;
      end
    end
  end

  // Mark store requests
  always_comb begin
    bm_req         = '0;
    bm_req.rd_en   = (state_q == S_READ);
    bm_req.wr_en   = (state_q == S_EVAL) && eval_ok;
    bm_req.clear   = cfg_count_we;
    bm_req.row     = row_q;
    bm_req.wr_word = eval_word;
  end

  fbpa_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bm_req),
    .rd_word_o (word)
  );

  // Next state and row
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
          row_d   = (func_i == fbpa_pkg::FUNC_FREE) ?
                    fbpa_pkg::ROW_W'(block_index_i >> fbpa_pkg::BIT_W) : '0;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (eval_ok) begin
          state_d = S_MUL;
        end else if (eval_fail) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
          row_d   = row_q + 1'b1;
        end
      end
      S_MUL: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, registers and free count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      row_q         <= '0;
      done_q        <= 1'b0;
      block_count_q <= fbpa_pkg::BLOCK_COUNT_RST;
      block_size_q  <= fbpa_pkg::BLOCK_SIZE_RST;
      free_count_q  <= fbpa_pkg::FREE_COUNT_RST;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      done_q  <= ((state_q == S_EVAL) && eval_fail) || (state_q == S_MUL);
      if (cfg_count_we) begin
        block_count_q <= cfg_data_i[fbpa_pkg::CNT_W-1:0];
        free_count_q  <= cfg_pool_n[fbpa_pkg::CNT_W-1:0];
      end else if ((state_q == S_EVAL) && eval_ok) begin
        if (func_q == fbpa_pkg::FUNC_ALLOC) begin
          if (free_count_q != '0) begin
            free_count_q <= free_count_q - 1'b1;
          end
        end else if (free_count_q != '1) begin
          free_count_q <= free_count_q + 1'b1;
        end
      end
      if (cfg_we && (cfg_index_i == fbpa_pkg::REG_BLOCK_SIZE)) begin
        block_size_q <= cfg_data_i;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      idx_q  <= block_index_i;
    end
    if ((state_q == S_EVAL) && eval_ok) begin
      grant_q <= eval_idx;
    end
    if ((state_q == S_EVAL) && eval_fail) begin
      status_q   <= fail_status;
      res_idx_q  <= '0;
      res_ofs_q  <= '0;
      res_free_q <= free_count_q;
    end else if (state_q == S_MUL) begin
      status_q   <= fbpa_pkg::STAT_DONE;
      res_idx_q  <= grant_q;
      res_ofs_q  <= fbpa_pkg::OFS_W'(grant_q) * fbpa_pkg::OFS_W'(block_size_q);
      res_free_q <= free_count_q;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_index_o  = res_idx_q;
  assign byte_offset_o    = res_ofs_q;
  assign free_remaining_o = res_free_q;

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |=> !done_o) else $error("result strobe held longer than one cycle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && (status_o != fbpa_pkg::STAT_DONE)) |->
      ((granted_index_o == '0) && (byte_offset_o == '0)))
      else $error("failed request reports a nonzero block");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept |=> busy) else $error("accepted request did not start the sequencer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ({1'b0, free_count_q} <= pool_n)) else $error("free count exceeds pool size");
`endif

endmodule

`default_nettype wire

FILE: test/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int DRAIN_LIMIT  = 2000;

  typedef struct packed {
    logic [1:0]                 status;
    logic [fbpa_pkg::IDX_W-1:0] index;
    logic [fbpa_pkg::OFS_W-1:0] offset;
    logic [fbpa_pkg::CNT_W-1:0] remaining;
  } pool_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One directed step: a request (sel = block index) or a register write (sel = reg index)
  typedef struct {
    row_kind_e    kind;
    logic         func;
    logic [7:0]   sel;
    logic [15:0]  data;
    bit           typed;
    pool_result_t want;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        func_i;
  logic [fbpa_pkg::IDX_W-1:0]  block_index_i;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [7:0]                  cfg_index_i;
  logic [fbpa_pkg::SIZE_W-1:0] cfg_data_i;
  logic                        done_o;
  logic [1:0]                  status_o;
  logic [fbpa_pkg::IDX_W-1:0]  granted_index_o;
  logic [fbpa_pkg::OFS_W-1:0]  byte_offset_o;
  logic [fbpa_pkg::CNT_W-1:0]  free_remaining_o;

  fixed_block_pool_allocator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .block_index_i    (block_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .byte_offset_o    (byte_offset_o),
    .free_remaining_o (free_remaining_o)
  );

  // Shadow copy of the pool
  bit                          used_mark [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::CNT_W-1:0]  pool_blocks;
  logic [fbpa_pkg::SIZE_W-1:0] pool_block_size;
  logic [fbpa_pkg::CNT_W-1:0]  pool_free;

  pool_result_t pending_results[$];
  stim_row_t    stim_rows[$];

  int errors    = 0;
  int cycles    = 0;
  int n_req     = 0;
  int n_grant   = 0;
  int n_empty   = 0;
  int n_bad     = 0;
  int n_cfg     = 0;
  int peak_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic void clear_pool_marks();
    foreach (used_mark[i]) used_mark[i] = 1'b0;
  endfunction

  function automatic void apply_pool_reg(logic [7:0] ri, logic [15:0] d);
    if (ri == fbpa_pkg::REG_BLOCK_COUNT) begin
      pool_blocks = d[fbpa_pkg::CNT_W-1:0];
      clear_pool_marks();
      pool_free = pool_blocks;
    end else if (ri == fbpa_pkg::REG_BLOCK_SIZE) begin
      pool_block_size = d;
    end
  endfunction

  // Lowest-free grant on allocate, mark release on free; updates the shadow pool
  function automatic pool_result_t predict_pool_request(logic f,
                                                        logic [fbpa_pkg::IDX_W-1:0] idx);
    pool_result_t r;
    int n;
    int i;
    n = pool_blocks;
    if (f == fbpa_pkg::FUNC_ALLOC) begin
      for (i = 0; i < n; i++) begin
        if (!used_mark[i]) break;
      end
      if (i >= n) begin
        n_empty++;
        r = '{fbpa_pkg::STAT_EMPTY, '0, '0, pool_free};
      end else begin
        used_mark[i] = 1'b1;
        if (pool_free > 0) pool_free--;
        n_grant++;
        if (int'(pool_blocks) - int'(pool_free) > peak_used)
          peak_used = int'(pool_blocks) - int'(pool_free);
        r = '{fbpa_pkg::STAT_DONE, fbpa_pkg::IDX_W'(i),
              fbpa_pkg::OFS_W'(i * int'(pool_block_size)), pool_free};
      end
    end else if (int'(idx) >= n || !used_mark[idx]) begin
      n_bad++;
      r = '{fbpa_pkg::STAT_BAD, '0, '0, pool_free};
    end else begin
      used_mark[idx] = 1'b0;
      if (pool_free < 8'd255) pool_free++;
      r = '{fbpa_pkg::STAT_DONE, idx,
            fbpa_pkg::OFS_W'(int'(idx) * int'(pool_block_size)), pool_free};
    end
    return r;
  endfunction

  // Any block currently allocated, else a random index
  function automatic logic [fbpa_pkg::IDX_W-1:0] pick_used_block();
    int n;
    int s;
    int k;
    n = pool_blocks;
    if (n > 0) begin
      s = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++) begin
        if (used_mark[(s + k) % n]) return fbpa_pkg::IDX_W'((s + k) % n);
      end
    end
    return fbpa_pkg::IDX_W'($urandom_range(0, 255));
  endfunction

  // Mostly back to back, some short gaps, a few long ones; no gaps when quiet
  function automatic int gap_cycles(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void add_req(logic f, logic [7:0] idx);
    stim_row_t row;
    row.kind  = ROW_REQ;
    row.func  = f;
    row.sel   = idx;
    row.data  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_check(logic f, logic [7:0] idx, logic [1:0] st,
                                    logic [fbpa_pkg::IDX_W-1:0] gi,
                                    logic [fbpa_pkg::OFS_W-1:0] ofs,
                                    logic [fbpa_pkg::CNT_W-1:0] rem);
    stim_row_t row;
    row.kind  = ROW_REQ;
    row.func  = f;
    row.sel   = idx;
    row.data  = '0;
    row.typed = 1'b1;
    row.want  = '{st, gi, ofs, rem};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [7:0] ri, logic [15:0] d);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.func  = fbpa_pkg::FUNC_ALLOC;
    row.sel   = ri;
    row.data  = d;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  // Present one item, hold it until taken, then log what it should return
  task automatic send_request(logic f, logic [fbpa_pkg::IDX_W-1:0] idx, int gap, bit typed,
                              pool_result_t want);
    pool_result_t predicted;
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start         = 1'b1;
    func_i        = f;
    block_index_i = idx;
    do @(posedge clk_i); while (busy);
    predicted = predict_pool_request(f, idx);
    pending_results.push_back(typed ? want : predicted);
    n_req++;
  endtask

  task automatic wait_pool_idle();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
  endtask

  task automatic write_pool_reg(logic [7:0] ri, logic [15:0] d);
    wait_pool_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = ri;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_pool_reg(ri, d);
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result checker: every strobe must match the oldest pending expectation
  always @(posedge clk_i) begin : result_check
    pool_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d", status_o,
               granted_index_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (granted_index_o !== want.index) begin
          $error("granted_index: expected %0d, got %0d", want.index, granted_index_o);
          errors++;
        end
        if (byte_offset_o !== want.offset) begin
          $error("byte_offset: expected %0d, got %0d", want.offset, byte_offset_o);
          errors++;
        end
        if (free_remaining_o !== want.remaining) begin
          $error("free_remaining: expected %0d, got %0d", want.remaining,
                 free_remaining_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int total;
    int phase_items;
    int alloc_pct;
    int k;
    int r;
    bit quiet;
    logic f;
    logic [fbpa_pkg::IDX_W-1:0] idx;
    logic [15:0] d;
    stim_row_t row;

    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = fbpa_pkg::FUNC_ALLOC;
    block_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;

    pool_blocks     = fbpa_pkg::BLOCK_COUNT_RST;
    pool_block_size = fbpa_pkg::BLOCK_SIZE_RST;
    pool_free       = fbpa_pkg::FREE_COUNT_RST;
    clear_pool_marks();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: after reset, double free, out of range, size and count extremes,
    // empty pool, zero-block pool, ignored register indexes
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_DONE, 0, 0, 254);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'hFF, fbpa_pkg::STAT_DONE, 1, 64, 253);
    add_check(fbpa_pkg::FUNC_FREE, 8'h00, fbpa_pkg::STAT_DONE, 0, 0, 254);
    add_check(fbpa_pkg::FUNC_FREE, 8'h00, fbpa_pkg::STAT_BAD, 0, 0, 254);
    add_check(fbpa_pkg::FUNC_FREE, 8'hFF, fbpa_pkg::STAT_BAD, 0, 0, 254);
    add_check(fbpa_pkg::FUNC_FREE, 8'h01, fbpa_pkg::STAT_DONE, 1, 64, 255);
    add_req(fbpa_pkg::FUNC_ALLOC, 8'h55);
    add_cfg(fbpa_pkg::REG_BLOCK_SIZE, 16'hFFFF);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_DONE, 1, 65535, 253);
    add_req(fbpa_pkg::FUNC_FREE, 8'hAA);
    add_cfg(fbpa_pkg::REG_BLOCK_COUNT, 16'h0001);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_DONE, 0, 0, 0);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_EMPTY, 0, 0, 0);
    add_check(fbpa_pkg::FUNC_FREE, 8'h01, fbpa_pkg::STAT_BAD, 0, 0, 0);
    add_check(fbpa_pkg::FUNC_FREE, 8'h00, fbpa_pkg::STAT_DONE, 0, 0, 1);
    add_cfg(fbpa_pkg::REG_BLOCK_COUNT, 16'h0000);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_EMPTY, 0, 0, 0);
    add_check(fbpa_pkg::FUNC_FREE, 8'h00, fbpa_pkg::STAT_BAD, 0, 0, 0);
    add_cfg(8'hFF, 16'hFFFF);
    add_cfg(8'h02, 16'h0003);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_EMPTY, 0, 0, 0);
    add_cfg(fbpa_pkg::REG_BLOCK_COUNT, 16'hFF02);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_DONE, 0, 0, 1);
    add_check(fbpa_pkg::FUNC_ALLOC, 8'h00, fbpa_pkg::STAT_DONE, 1, 65535, 0);
    add_cfg(fbpa_pkg::REG_BLOCK_SIZE, 16'h0001);
    add_check(fbpa_pkg::FUNC_FREE, 8'h01, fbpa_pkg::STAT_DONE, 1, 1, 1);
    add_cfg(fbpa_pkg::REG_BLOCK_COUNT, 16'h00FF);
    add_req(fbpa_pkg::FUNC_FREE, 8'hFE);
    add_req(fbpa_pkg::FUNC_ALLOC, 8'h00);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) write_pool_reg(row.sel, row.data);
      else send_request(row.func, row.sel, gap_cycles(1'b0), row.typed, row.want);
    end

    // Random phases: optional reconfiguration, then a burst with a set alloc bias
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        if (r == 0)      d = 16'h00FF;
        else if (r == 1) d = 16'h0000;
        else if (r == 2) d = 16'($urandom_range(0, 255));
        else             d = 16'($urandom_range(1, 16));
        d[15:8] = 8'($urandom);
        write_pool_reg(fbpa_pkg::REG_BLOCK_COUNT, d);
      end
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 3);
        if (r == 0)      d = 16'h0001;
        else if (r == 1) d = 16'hFFFF;
        else             d = 16'($urandom_range(0, 65535));
        write_pool_reg(fbpa_pkg::REG_BLOCK_SIZE, d);
      end
      if ($urandom_range(0, 5) == 0)
        write_pool_reg(8'($urandom_range(2, 255)), 16'($urandom));

      r = $urandom_range(0, 3);
      alloc_pct   = (r == 0) ? 25 : (r == 1) ? 50 : (r == 2) ? 75 : 90;
      quiet       = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(60, 140);
      for (k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          f   = fbpa_pkg::FUNC_ALLOC;
          idx = fbpa_pkg::IDX_W'($urandom);
        end else begin
          f = fbpa_pkg::FUNC_FREE;
          r = $urandom_range(0, 9);
          if (r < 7)      idx = pick_used_block();
          else if (r < 9) idx = fbpa_pkg::IDX_W'($urandom_range(0, 255));
          else            idx = fbpa_pkg::IDX_W'($urandom_range(pool_blocks, 255));
        end
        send_request(f, idx, gap_cycles(quiet), 1'b0, '0);
      end
      total += phase_items;
    end

    // Drain
    @(negedge clk_i);
    start = 1'b0;
    k = 0;
    while (pending_results.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk_i);
      k++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d requests: %0d grants, %0d empty pools, %0d bad frees",
             n_req, n_grant, n_empty, n_bad);
    $display("Register writes %0d, peak blocks in use %0d, mismatches %0d",
             n_cfg, peak_used, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fbpa_pkg.sv
rtl/fbpa_bitmap.sv
rtl/fixed_block_pool_allocator.sv
test/tb_fixed_block_pool_allocator.sv
